@@ design/cbpf_pkg.sv @@
// Shared constants and types for the crop box point filter.
// Holds parameter defaults, register reset values and the register index codes.
// No dependencies.
package cbpf_pkg;

  localparam int COORD_BITS_DEFAULT     = 24;
  localparam int TRIG_FRAC_BITS_DEFAULT = 14;

  // The cosine and sine registers are always 16 bits wide.
  localparam int TRIG_BITS = 16;

  localparam logic signed [TRIG_BITS-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TRIG_BITS-1:0] SIN_RESET = 16'sd0;

  // Reset half extent is 0.5 m at 1/1024 m per step.
  localparam int HALF_RESET = 512;

  typedef enum logic [2:0] {
    REG_COS_YAW  = 3'd0,
    REG_SIN_YAW  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_OFFSET_Z = 3'd4,
    REG_HALF_X   = 3'd5,
    REG_HALF_Y   = 3'd6,
    REG_HALF_Z   = 3'd7
  } reg_index_t;

endpackage

@@ design/cbpf_cfg.sv @@
// Configuration register file of the crop box point filter.
// Decodes the write port into the box pose and extent registers; uses cbpf_pkg.
module cbpf_cfg #(
  parameter int COORD_BITS = cbpf_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_wdata,
  output logic signed [cbpf_pkg::TRIG_BITS-1:0]  cos_yaw,
  output logic signed [cbpf_pkg::TRIG_BITS-1:0]  sin_yaw,
  output logic signed [COORD_BITS-1:0]           offset_x,
  output logic signed [COORD_BITS-1:0]           offset_y,
  output logic signed [COORD_BITS-1:0]           offset_z,
  output logic [COORD_BITS-2:0]                  half_x,
  output logic [COORD_BITS-2:0]                  half_y,
  output logic [COORD_BITS-2:0]                  half_z
);

  localparam logic [COORD_BITS-2:0] HalfReset = (COORD_BITS-1)'(cbpf_pkg::HALF_RESET);

  cbpf_pkg::reg_index_t index;

  assign index = cbpf_pkg::reg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_yaw  <= cbpf_pkg::COS_RESET;
      sin_yaw  <= cbpf_pkg::SIN_RESET;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      half_x   <= HalfReset;
      half_y   <= HalfReset;
      half_z   <= HalfReset;
    end else if (cfg_we) begin
      unique case (index)
        cbpf_pkg::REG_COS_YAW:  cos_yaw  <= $signed(cfg_wdata[cbpf_pkg::TRIG_BITS-1:0]);
        cbpf_pkg::REG_SIN_YAW:  sin_yaw  <= $signed(cfg_wdata[cbpf_pkg::TRIG_BITS-1:0]);
        cbpf_pkg::REG_OFFSET_X: offset_x <= $signed(cfg_wdata);
        cbpf_pkg::REG_OFFSET_Y: offset_y <= $signed(cfg_wdata);
        cbpf_pkg::REG_OFFSET_Z: offset_z <= $signed(cfg_wdata);
        cbpf_pkg::REG_HALF_X:   half_x   <= cfg_wdata[COORD_BITS-2:0];
        cbpf_pkg::REG_HALF_Y:   half_y   <= cfg_wdata[COORD_BITS-2:0];
        cbpf_pkg::REG_HALF_Z:   half_z   <= cfg_wdata[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/cbpf_xform.sv @@
// Offset removal and rotation products of the crop box point filter.
// Two pipeline stages: difference registers, then four product registers; uses cbpf_pkg.
module cbpf_xform #(
  parameter int COORD_BITS = cbpf_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          advance,
  input  logic                                          in_beat,
  input  logic signed [COORD_BITS-1:0]                  in_x,
  input  logic signed [COORD_BITS-1:0]                  in_y,
  input  logic signed [COORD_BITS-1:0]                  in_z,
  input  logic signed [cbpf_pkg::TRIG_BITS-1:0]         cos_yaw,
  input  logic signed [cbpf_pkg::TRIG_BITS-1:0]         sin_yaw,
  input  logic signed [COORD_BITS-1:0]                  offset_x,
  input  logic signed [COORD_BITS-1:0]                  offset_y,
  input  logic signed [COORD_BITS-1:0]                  offset_z,
  output logic                                          prod_valid,
  output logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_cx,
  output logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_sy,
  output logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_cy,
  output logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_sx,
  output logic signed [COORD_BITS:0]                    prod_dz
);

  localparam int PW = COORD_BITS + cbpf_pkg::TRIG_BITS + 1;

  logic                      diff_valid;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] dz;

  logic signed [PW-1:0] prod_cx_next;
  logic signed [PW-1:0] prod_sy_next;
  logic signed [PW-1:0] prod_cy_next;
  logic signed [PW-1:0] prod_sx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else if (advance) begin
      diff_valid <= in_beat;
      prod_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx <= (COORD_BITS+1)'(in_x) - (COORD_BITS+1)'(offset_x);
      dy <= (COORD_BITS+1)'(in_y) - (COORD_BITS+1)'(offset_y);
      dz <= (COORD_BITS+1)'(in_z) - (COORD_BITS+1)'(offset_z);
    end
  end

  assign prod_cx_next = PW'(cos_yaw) * PW'(dx);
  assign prod_sy_next = PW'(sin_yaw) * PW'(dy);
  assign prod_cy_next = PW'(cos_yaw) * PW'(dy);
  assign prod_sx_next = PW'(sin_yaw) * PW'(dx);

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_cx <= prod_cx_next;
      prod_sy <= prod_sy_next;
      prod_cy <= prod_cy_next;
      prod_sx <= prod_sx_next;
      prod_dz <= dz;
    end
  end

endmodule

@@ design/cbpf_bounds.sv @@
// Box test and result register of the crop box point filter.
// Sums the rotation products, drops the fraction, checks the box faces; uses cbpf_pkg.
module cbpf_bounds #(
  parameter int COORD_BITS     = cbpf_pkg::COORD_BITS_DEFAULT,
  parameter int TRIG_FRAC_BITS = cbpf_pkg::TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          advance,
  input  logic                                          prod_valid,
  input  logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_cx,
  input  logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_sy,
  input  logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_cy,
  input  logic signed [COORD_BITS+cbpf_pkg::TRIG_BITS:0] prod_sx,
  input  logic signed [COORD_BITS:0]                    prod_dz,
  input  logic [COORD_BITS-2:0]                         half_x,
  input  logic [COORD_BITS-2:0]                         half_y,
  input  logic [COORD_BITS-2:0]                         half_z,
  output logic                                          out_valid,
  output logic signed [COORD_BITS-1:0]                  out_x,
  output logic signed [COORD_BITS-1:0]                  out_y,
  output logic signed [COORD_BITS-1:0]                  out_z
);

  localparam int SW = COORD_BITS + cbpf_pkg::TRIG_BITS + 2;
  localparam int DW = COORD_BITS + 1;

  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] box_x;
  logic signed [SW-1:0] box_y;
  logic signed [SW-1:0] lim_x;
  logic signed [SW-1:0] lim_y;
  logic signed [DW-1:0] lim_z;
  logic                 in_box;

  // Arithmetic shift of the signed sum rounds toward minus infinity.
  assign sum_x = SW'(prod_cx) + SW'(prod_sy);
  assign sum_y = SW'(prod_cy) - SW'(prod_sx);
  assign box_x = sum_x >>> TRIG_FRAC_BITS;
  assign box_y = sum_y >>> TRIG_FRAC_BITS;

  assign lim_x = $signed(SW'(half_x));
  assign lim_y = $signed(SW'(half_y));
  assign lim_z = $signed(DW'(half_z));

  assign in_box = (box_x > -lim_x) && (box_x < lim_x) &&
                  (box_y > -lim_y) && (box_y < lim_y) &&
                  (prod_dz > -lim_z) && (prod_dz < lim_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= prod_valid && in_box;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x <= box_x[COORD_BITS-1:0];
      out_y <= box_y[COORD_BITS-1:0];
      out_z <= prod_dz[COORD_BITS-1:0];
    end
  end

endmodule

@@ design/crop_box_point_filter_top.sv @@
// Crop box point filter: offsets, rotates and box-tests one 3D point per beat.
// Uses cbpf_pkg and instantiates cbpf_cfg, cbpf_xform and cbpf_bounds.
//
// The filter takes one point per clock cycle unless a result waits on the output. A
// kept point passes the difference, product and result registers in that order;
// invalid points and points on or outside a box face produce no output beat.
// The three-stage pipeline (difference, products, box test with result register)
// moves as one unit and holds only while a result waits on the output, so in_ready
// is high while the output is empty or out_ready is high.
// Configuration registers take effect on the next cycle and are meant to be
// written while no points are in flight.
module crop_box_point_filter_top #(
  parameter int COORD_BITS     = cbpf_pkg::COORD_BITS_DEFAULT,
  parameter int TRIG_FRAC_BITS = cbpf_pkg::TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  logic                         point_valid,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_wdata
);

  localparam int PW = COORD_BITS + cbpf_pkg::TRIG_BITS + 1;

  logic signed [cbpf_pkg::TRIG_BITS-1:0] cos_yaw;
  logic signed [cbpf_pkg::TRIG_BITS-1:0] sin_yaw;
  logic signed [COORD_BITS-1:0]          offset_x;
  logic signed [COORD_BITS-1:0]          offset_y;
  logic signed [COORD_BITS-1:0]          offset_z;
  logic [COORD_BITS-2:0]                 half_x;
  logic [COORD_BITS-2:0]                 half_y;
  logic [COORD_BITS-2:0]                 half_z;

  logic                    advance;
  logic                    in_beat;
  logic                    prod_valid;
  logic signed [PW-1:0]    prod_cx;
  logic signed [PW-1:0]    prod_sy;
  logic signed [PW-1:0]    prod_cy;
  logic signed [PW-1:0]    prod_sx;
  logic signed [COORD_BITS:0] prod_dz;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign in_beat  = in_valid && point_valid;

  cbpf_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cos_yaw   (cos_yaw),
    .sin_yaw   (sin_yaw),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .offset_z  (offset_z),
    .half_x    (half_x),
    .half_y    (half_y),
    .half_z    (half_z)
  );

  cbpf_xform #(
    .COORD_BITS (COORD_BITS)
  ) u_xform (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_beat    (in_beat),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .cos_yaw    (cos_yaw),
    .sin_yaw    (sin_yaw),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .offset_z   (offset_z),
    .prod_valid (prod_valid),
    .prod_cx    (prod_cx),
    .prod_sy    (prod_sy),
    .prod_cy    (prod_cy),
    .prod_sx    (prod_sx),
    .prod_dz    (prod_dz)
  );

  cbpf_bounds #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_bounds (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .prod_valid (prod_valid),
    .prod_cx    (prod_cx),
    .prod_sy    (prod_sy),
    .prod_cy    (prod_cy),
    .prod_sx    (prod_sx),
    .prod_dz    (prod_dz),
    .half_x     (half_x),
    .half_y     (half_y),
    .half_z     (half_z),
    .out_valid  (out_valid),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for crop_box_point_filter_top: point stream in, kept points out.
// Predicts each kept point from its own copy of the box registers; depends on cbpf_pkg.
// Covers directed face cases, then random box settings with random idling and stalls.
module tb_top;

  localparam int    COORD      = cbpf_pkg::COORD_BITS_DEFAULT;
  localparam int    FRAC       = cbpf_pkg::TRIG_FRAC_BITS_DEFAULT;
  localparam longint COS_ONE   = 16384;
  localparam longint COORD_MAX = 8388607;
  localparam longint COORD_MIN = -8388608;
  localparam longint HALF_MAX  = 8388607;
  localparam int    DRAIN_CYCLES = 8;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    PHASE_ITEMS  = 110;

  typedef struct {
    logic signed [COORD-1:0] x;
    logic signed [COORD-1:0] y;
    logic signed [COORD-1:0] z;
    logic                    usable;
  } point_t;

  typedef struct {
    logic signed [COORD-1:0] x;
    logic signed [COORD-1:0] y;
    logic signed [COORD-1:0] z;
  } box_point_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [COORD-1:0] in_x = '0;
  logic signed [COORD-1:0] in_y = '0;
  logic signed [COORD-1:0] in_z = '0;
  logic                    point_valid = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [COORD-1:0] out_x;
  logic signed [COORD-1:0] out_y;
  logic signed [COORD-1:0] out_z;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [COORD-1:0]        cfg_wdata = '0;

  point_t     point_q[$];
  box_point_t kept_q[$];

  longint box_cos = COS_ONE;
  longint box_sin = 0;
  longint box_off_x = 0;
  longint box_off_y = 0;
  longint box_off_z = 0;
  longint box_half_x = cbpf_pkg::HALF_RESET;
  longint box_half_y = cbpf_pkg::HALF_RESET;
  longint box_half_z = cbpf_pkg::HALF_RESET;

  bit in_busy = 1'b1;
  bit out_busy = 1'b1;
  int in_gap = 0;
  int out_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;

  crop_box_point_filter_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .point_valid (point_valid),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit crop_point(input point_t p, output box_point_t b);
    longint dx, dy, dz, bx, by;
    b = '{default: '0};
    if (!p.usable) return 1'b0;
    dx = longint'(p.x) - box_off_x;
    dy = longint'(p.y) - box_off_y;
    dz = longint'(p.z) - box_off_z;
    bx = (box_cos * dx + box_sin * dy) >>> FRAC;
    by = (box_cos * dy - box_sin * dx) >>> FRAC;
    if (!(bx > -box_half_x && bx < box_half_x)) return 1'b0;
    if (!(by > -box_half_y && by < box_half_y)) return 1'b0;
    if (!(dz > -box_half_z && dz < box_half_z)) return 1'b0;
    b.x = bx[COORD-1:0];
    b.y = by[COORD-1:0];
    b.z = dz[COORD-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: one beat per pending point; a random gap follows each accepted beat if in_busy.
  always @(posedge clk) begin
    point_t     nxt;
    box_point_t kept;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (crop_point('{in_x, in_y, in_z, point_valid}, kept))
          kept_q.insert(kept_q.size(), kept);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (point_q.size() != 0) begin
          nxt = point_q.pop_front();
          in_x        <= nxt.x;
          in_y        <= nxt.y;
          in_z        <= nxt.z;
          point_valid <= nxt.usable;
          in_valid    <= 1'b1;
          in_gap      <= in_busy ? $urandom_range(0, 13) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest predicted point.
  always @(posedge clk) begin
    box_point_t want;
    int         stall_n;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      stall_n = out_stall;
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          report_mismatch("result with none pending, x", longint'(out_x), 0);
        end else begin
          want = kept_q.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", longint'(out_x), longint'(want.x));
          if (out_y !== want.y) report_mismatch("out_y", longint'(out_y), longint'(want.y));
          if (out_z !== want.z) report_mismatch("out_z", longint'(out_z), longint'(want.z));
        end
        stall_n = out_busy ? $urandom_range(0, 13) : 0;
      end else if (stall_n != 0) begin
        stall_n--;
      end
      out_stall <= stall_n;
      out_ready <= (stall_n == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold-off, started on request while the sender keeps offering points.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[crop_box_point_filter_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input cbpf_pkg::reg_index_t idx, input longint val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[COORD-1:0];
    case (idx)
      cbpf_pkg::REG_COS_YAW:  box_cos    = val;
      cbpf_pkg::REG_SIN_YAW:  box_sin    = val;
      cbpf_pkg::REG_OFFSET_X: box_off_x  = val;
      cbpf_pkg::REG_OFFSET_Y: box_off_y  = val;
      cbpf_pkg::REG_OFFSET_Z: box_off_z  = val;
      cbpf_pkg::REG_HALF_X:   box_half_x = val;
      cbpf_pkg::REG_HALF_Y:   box_half_y = val;
      cbpf_pkg::REG_HALF_Z:   box_half_z = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_box(input longint c, input longint s, input longint ox, input longint oy,
                         input longint oz, input longint hx, input longint hy, input longint hz);
    write_reg(cbpf_pkg::REG_COS_YAW, c);
    write_reg(cbpf_pkg::REG_SIN_YAW, s);
    write_reg(cbpf_pkg::REG_OFFSET_X, ox);
    write_reg(cbpf_pkg::REG_OFFSET_Y, oy);
    write_reg(cbpf_pkg::REG_OFFSET_Z, oz);
    write_reg(cbpf_pkg::REG_HALF_X, hx);
    write_reg(cbpf_pkg::REG_HALF_Y, hy);
    write_reg(cbpf_pkg::REG_HALF_Z, hz);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point(input longint x, input longint y, input longint z, input bit ok);
    point_t p;
    p.x = x[COORD-1:0];
    p.y = y[COORD-1:0];
    p.z = z[COORD-1:0];
    p.usable = ok;
    point_q.insert(point_q.size(), p);
  endtask

  function automatic longint rand_span(input longint r);
    return longint'($urandom_range(0, int'(2 * r))) - r;
  endfunction

  function automatic longint rand_coord();
    logic signed [COORD-1:0] v;
    v = COORD'($urandom());
    return longint'(v);
  endfunction

  function automatic longint rand_half();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(1, 64));
      1: return $urandom_range(0, 1) ? HALF_MAX : longint'($urandom_range(1000000, 8388607));
      default: return longint'($urandom_range(64, 40000));
    endcase
  endfunction

  // Coordinate along one box axis: often right at a face, otherwise around the box.
  function automatic longint box_axis(input longint h);
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) ? h : -h) + rand_span(2);
    return rand_span(h + h / 2 + 4);
  endfunction

  task automatic queue_random(input int n);
    longint ux, uy, uz;
    int     kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        ux = box_axis(box_half_x);
        uy = box_axis(box_half_y);
        uz = box_axis(box_half_z);
        queue_point(box_off_x + ((box_cos * ux - box_sin * uy) >>> FRAC),
                    box_off_y + ((box_sin * ux + box_cos * uy) >>> FRAC),
                    box_off_z + uz, 1'b1);
      end else begin
        queue_point(rand_coord(), rand_coord(), rand_coord(), kind != 9);
      end
    end
  endtask

  // The last point may leave the queue in the same cycle as the check, so the
  // check is repeated after the drain.
  task automatic wait_idle();
    do begin
      while (point_q.size() != 0 || in_valid || kept_q.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (point_q.size() != 0 || in_valid || kept_q.size() != 0);
  endtask

  initial begin
    int     waited;
    longint c, s;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset box: identity rotation, origin at zero, half extent of 512 on every axis.
    queue_point(0, 0, 0, 1'b1);
    queue_point(511, 0, 0, 1'b1);
    queue_point(512, 0, 0, 1'b1);
    queue_point(-511, 0, 0, 1'b1);
    queue_point(-512, 0, 0, 1'b1);
    queue_point(0, 511, 0, 1'b1);
    queue_point(0, -512, 0, 1'b1);
    queue_point(0, -511, 511, 1'b1);
    queue_point(0, 0, -511, 1'b1);
    queue_point(0, 0, 512, 1'b1);
    queue_point(1, -1, 1, 1'b1);
    queue_point(-1, -1, -1, 1'b1);
    queue_point(0, 0, 0, 1'b0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    queue_point(-1, -1, -1, 1'b0);
    queue_point(100, -200, 300, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      in_busy  = $urandom_range(0, 2) != 0;
      out_busy = $urandom_range(0, 2) != 0;
      case (phase)
        0: set_box(COS_ONE, 0, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX);
        1: set_box(-COS_ONE, 0, COORD_MAX, COORD_MIN, COORD_MAX, 3000, 200, 70000);
        2: set_box(0, COS_ONE, COORD_MIN, COORD_MAX, COORD_MIN, rand_half(), rand_half(),
                   rand_half());
        3: set_box(0, -COS_ONE, rand_coord(), rand_coord(), rand_coord(), rand_half(),
                   rand_half(), rand_half());
        4: begin
          in_busy  = 1'b0;
          out_busy = 1'b0;
          set_box(11585, 11585, rand_coord(), rand_coord(), rand_coord(), rand_half(),
                  rand_half(), rand_half());
        end
        5: set_box(-11585, -11585, rand_coord(), rand_coord(), rand_coord(), rand_half(),
                   rand_half(), rand_half());
        6: begin
          c = longint'($urandom_range(0, 32768)) - COS_ONE;
          s = longint'($urandom_range(0, 32768)) - COS_ONE;
          set_box(c, s, rand_coord(), rand_coord(), rand_coord(), rand_half(), rand_half(),
                  rand_half());
        end
        7: set_box(COS_ONE, 0, rand_coord(), rand_coord(), rand_coord(), 0, HALF_MAX, 0);
        8: set_box(COS_ONE, -COS_ONE, rand_coord(), rand_coord(), rand_coord(), 1, 1, 1);
        default: set_box(longint'(cbpf_pkg::COS_RESET), longint'(cbpf_pkg::SIN_RESET), 0, 0,
                         0, cbpf_pkg::HALF_RESET, cbpf_pkg::HALF_RESET,
                         cbpf_pkg::HALF_RESET);
      endcase
      queue_random(PHASE_ITEMS);
      if (phase == 2 || phase == 6) hold_req++;
      wait_idle();
    end

    waited = 0;
    while (kept_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (kept_q.size() != 0) report_mismatch("points never emitted", 0, longint'(kept_q.size()));
    if (errors == 0) begin
      $display("[crop_box_point_filter_top] OK");
    end else begin
      $display("[crop_box_point_filter_top] ERROR");
    end
    $finish;
  end

endmodule
